### hw/rtl/rfr_pkg.sv
package rfr_pkg;

  localparam int unsigned MaxInstances = 256;
  localparam int unsigned MaxFeatures  = 32;
  localparam int unsigned ValueWidth   = 16;
  localparam int unsigned ResultLimit  = 32;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 9;

  localparam logic [CfgIdxW-1:0] RegInstanceCount = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFeatureCount  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegIterations    = 2'd2;
  localparam logic [CfgIdxW-1:0] RegTopCount      = 2'd3;

  typedef enum logic [4:0] {
    StLoad,
    StMmRd,
    StMmWait,
    StMmUpd,
    StTgtInit,
    StRowInit,
    StDistRd,
    StDistWait,
    StDistAcc,
    StRowDone,
    StTermInit,
    StTermRd,
    StTermWait,
    StTermDiv,
    StTermAcc,
    StSelInit,
    StSelScan,
    StSelMark,
    StEmit,
    StOut
  } rfr_state_e;

  typedef struct packed {
    logic start;
    logic busy;
  } rfr_div_ctrl_t;

endpackage

### hw/rtl/rfr_divider.sv
module rfr_divider #(
  parameter int unsigned NumW = 48,
  parameter int unsigned DenW = 33
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [NumW-1:0]      num_i,
  input  logic [DenW-1:0]      den_i,
  output logic                 busy_o,
  output logic [NumW-1:0]      quot_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quot_q, quot_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [DenW:0]   trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[DenW-1:0], quot_q[NumW-1]};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d  = trial - {1'b0, den_q};
        quot_d = {quot_q[NumW-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
endmodule

### hw/rtl/relief_feature_ranker_core.sv
// Loading: one value beat per cycle, ready every cycle until end_of_set.
// Ranking, input not ready: a min/max sweep, then per target a hit/miss search and
// 2*F terms on the shared bit-serial divider, then top-T selection.
// Output: one index beat per selected feature in ascending order, via StEmit and StOut;
// unselected indices are skipped in StEmit, which waits while a pending beat is not taken.
// Asynchronous active-low reset clears control; the instance store is not cleared.
module relief_feature_ranker_core
  import rfr_pkg::*;
#(
  parameter int unsigned MAX_INSTANCES = rfr_pkg::MaxInstances,
  parameter int unsigned MAX_FEATURES  = rfr_pkg::MaxFeatures,
  parameter int unsigned VALUE_WIDTH   = rfr_pkg::ValueWidth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [VALUE_WIDTH-1:0]     value_i,
  input  logic                              end_of_set_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [4:0]                        feature_index_o,
  output logic                              last_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rfr_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [rfr_pkg::CfgDataW-1:0]      cfg_data_i
);
  localparam int unsigned Depth = MAX_INSTANCES * (MAX_FEATURES + 1);
  localparam int unsigned AW    = $clog2(Depth + 1);
  localparam int unsigned RW    = $clog2(MAX_INSTANCES + 1);
  localparam int unsigned FW    = $clog2(MAX_FEATURES + 1);
  localparam int unsigned JW    = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int unsigned DW    = VALUE_WIDTH + 1;
  localparam int unsigned SW    = DW + $clog2(MAX_FEATURES + 1);
  localparam int unsigned NumW  = DW + 16;
  localparam int unsigned WW    = 16 + 2 + $clog2(MAX_INSTANCES + 1);
  localparam int unsigned TW    = (MAX_FEATURES < ResultLimit) ? FW : 6;

  logic signed [VALUE_WIDTH-1:0] mem [Depth];
  logic signed [VALUE_WIDTH-1:0] rd_q;
  logic [AW-1:0] rd_addr;
  logic          mem_we;

  logic signed [VALUE_WIDTH-1:0] fmax_q [MAX_FEATURES];
  logic signed [VALUE_WIDTH-1:0] fmin_q [MAX_FEATURES];
  logic signed [WW-1:0]          w_q    [MAX_FEATURES];
  logic [MAX_FEATURES-1:0]       sel_q;

  logic [8:0] cfg_n_q;
  logic [5:0] cfg_f_q;
  logic [8:0] cfg_m_q;
  logic [5:0] cfg_t_q;

  rfr_state_e st_q, st_d;
  logic [AW-1:0] lpos_q;
  logic [RW-1:0] n_q, m_q, r_q, i_q;
  logic [FW-1:0] nf_q;
  logic [TW-1:0] t_q, k_q;
  logic [JW-1:0] j_q, best_q;
  logic [FW-1:0] jc_q;
  logic          found_q;
  logic [AW-1:0] base_r_q, base_i_q;
  logic signed [VALUE_WIDTH-1:0] a_q;
  logic [SW-1:0] dist_q;
  logic          phase_q;
  logic [SW-1:0] bh_q, bm_q;
  logic          hh_q, hm_q;
  logic [RW-1:0] hr_q, mr_q;
  logic          tp_q;
  logic [4:0]    oidx_q;
  logic          olast_q;
  logic          ovalid_q;

  logic          div_start;
  logic          div_busy;
  logic [NumW-1:0] div_num;
  logic [DW-1:0]   div_den;
  logic [NumW-1:0] div_quot;
  logic [DW-1:0]   range_q;

  logic [RW-1:0] n_c, m_c;
  logic [FW-1:0] nf_c;
  logic [TW-1:0] t_c, lim_c;

  always_comb begin
    n_c  = (32'(cfg_n_q) > MAX_INSTANCES) ? RW'(MAX_INSTANCES) : RW'(cfg_n_q);
    nf_c = (cfg_f_q == '0) ? FW'(1) :
           ((32'(cfg_f_q) > MAX_FEATURES) ? FW'(MAX_FEATURES) : FW'(cfg_f_q));
    m_c  = (32'(cfg_m_q) > 32'(n_c)) ? n_c : RW'(cfg_m_q);
    lim_c = (32'(nf_c) < ResultLimit) ? TW'(nf_c) : TW'(ResultLimit);
    t_c  = (cfg_t_q == '0) ? TW'(1) :
           ((32'(cfg_t_q) > 32'(lim_c)) ? lim_c : TW'(cfg_t_q));
  end

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_n_q <= 9'd2;
      cfg_f_q <= 6'd1;
      cfg_m_q <= 9'd1;
      cfg_t_q <= 6'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegInstanceCount: cfg_n_q <= cfg_data_i;
        RegFeatureCount:  cfg_f_q <= cfg_data_i[5:0];
        RegIterations:    cfg_m_q <= cfg_data_i;
        RegTopCount:      cfg_t_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = (st_q == StLoad);
  assign mem_we = in_valid_i && in_ready_o && (32'(lpos_q) < Depth);

  // store read address by state; min/max and distance reads hold it through the wait state
  logic [AW-1:0] stride;
  assign stride = AW'(nf_q) + AW'(1);
  always_comb begin
    rd_addr = '0;
    unique case (st_q)
      StMmRd, StMmWait:     rd_addr = base_i_q + AW'(j_q);
      StDistRd, StDistWait: rd_addr = (phase_q ? base_i_q : base_r_q) + AW'(jc_q);
      StTermRd:             rd_addr = (phase_q ? base_i_q : base_r_q) + AW'(j_q);
      default:              rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[lpos_q[AW-1:0]] <= value_i;
    rd_q <= mem[rd_addr];
  end

  logic [DW-1:0] ad_c;
  logic signed [DW-1:0] sa, sb;
  assign sa = DW'(a_q);
  assign sb = DW'(rd_q);
  assign ad_c = (sa >= sb) ? DW'(sa - sb) : DW'(sb - sa);

  logic signed [DW-1:0] rng_c;
  assign rng_c = DW'(fmax_q[j_q]) - DW'(fmin_q[j_q]);

  assign div_num = {ad_c, 16'd0};
  assign div_den = rng_c;

  rfr_divider #(.NumW(NumW), .DenW(DW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  logic [15:0] q_sat;
  assign q_sat = (div_quot > NumW'(65535)) ? 16'hFFFF : div_quot[15:0];

  logic last_row, last_j, last_jc;
  assign last_row = (n_q == '0) || (i_q == n_q - RW'(1));
  assign last_j   = (32'(j_q) == 32'(nf_q) - 1);
  assign last_jc  = (jc_q == nf_q);

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StLoad:     if (in_valid_i && end_of_set_i) st_d = StMmRd;
      StMmRd:     st_d = StMmWait;
      StMmWait:   st_d = StMmUpd;
      StMmUpd:    if (last_row && last_j) st_d = StTgtInit;
                  else st_d = StMmRd;
      StTgtInit:  st_d = (r_q == m_q) ? StSelInit : StRowInit;
      StRowInit:  st_d = (i_q == r_q) ? StRowDone : StDistRd;
      StDistRd:   st_d = StDistWait;
      StDistWait: st_d = StDistAcc;
      StDistAcc:  st_d = (phase_q && last_jc) ? StRowDone : StDistRd;
      StRowDone:  st_d = last_row ? StTermInit : StRowInit;
      StTermInit: st_d = StTermRd;
      StTermRd:   st_d = StTermWait;
      StTermWait: st_d = phase_q ? StTermDiv : StTermRd;
      StTermDiv:  if (!div_busy && !div_start) st_d = StTermAcc;
      StTermAcc:  st_d = (tp_q && last_j) ? StTgtInit : StTermRd;
      StSelInit:  st_d = StSelScan;
      StSelScan:  if (last_j) st_d = StSelMark;
      StSelMark:  st_d = (k_q == t_q - TW'(1)) ? StEmit : StSelScan;
      StEmit:     if (!ovalid_q || out_ready_i) begin
                    if (sel_q[j_q]) st_d = StOut;
                    else if (last_j) st_d = StLoad;
                  end
      StOut:      st_d = (last_j || olast_q) ? StLoad : StEmit;
      default:    st_d = StLoad;
    endcase
  end

  // whether any selected index lies above j
  logic more_after;
  always_comb begin
    more_after = 1'b0;
    for (int x = 0; x < MAX_FEATURES; x++) begin
      if (32'(x) > 32'(j_q) && sel_q[x]) more_after = 1'b1;
    end
  end

  logic [SW-1:0] dsum;
  assign dsum = dist_q + SW'(ad_c);

  assign div_start = (st_q == StTermWait) && phase_q;

  logic emit_load;
  assign emit_load = (st_q == StEmit) && (!ovalid_q || out_ready_i) && sel_q[j_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StLoad; lpos_q <= '0; n_q <= '0; m_q <= '0; nf_q <= FW'(1);
      t_q <= '0; k_q <= '0; r_q <= '0; i_q <= '0; j_q <= '0; jc_q <= '0;
      phase_q <= 1'b0; hh_q <= 1'b0; hm_q <= 1'b0; hr_q <= '0; mr_q <= '0;
      bh_q <= '1; bm_q <= '1; tp_q <= 1'b0; found_q <= 1'b0; best_q <= '0;
      sel_q <= '0; ovalid_q <= 1'b0; olast_q <= 1'b0; oidx_q <= '0;
      base_r_q <= '0; base_i_q <= '0;
    end else begin
      st_q <= st_d;
      if (emit_load) ovalid_q <= 1'b1;
      else if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      unique case (st_q)
        StLoad: if (in_valid_i) begin
          if (end_of_set_i) begin
            lpos_q <= '0; n_q <= n_c; m_q <= m_c; nf_q <= nf_c; t_q <= t_c;
            i_q <= '0; j_q <= '0; base_i_q <= '0;
          end else if (32'(lpos_q) < Depth) begin
            lpos_q <= lpos_q + AW'(1);
          end
        end
        StMmRd, StMmWait: ;
        StMmUpd: begin
          if (i_q == '0 || rd_q > fmax_q[j_q]) fmax_q[j_q] <= rd_q;
          if (i_q == '0 || rd_q < fmin_q[j_q]) fmin_q[j_q] <= rd_q;
          if (last_row) begin
            i_q <= '0; base_i_q <= '0; j_q <= j_q + JW'(1);
            if (last_j) begin
              r_q <= '0; base_r_q <= '0;
              for (int x = 0; x < MAX_FEATURES; x++) w_q[x] <= '0;
            end
          end else begin
            i_q <= i_q + RW'(1); base_i_q <= base_i_q + stride;
          end
        end
        StTgtInit: begin
          hh_q <= 1'b0; hm_q <= 1'b0; bh_q <= '1; bm_q <= '1;
          hr_q <= '0; mr_q <= '0; i_q <= '0; base_i_q <= '0;
          sel_q <= '0; k_q <= '0;
        end
        StRowInit: begin
          dist_q <= '0; jc_q <= '0; phase_q <= 1'b0;
        end
        StDistRd, StDistWait: ;
        StDistAcc: begin
          if (!phase_q) begin
            a_q <= rd_q; phase_q <= 1'b1;
          end else begin
            phase_q <= 1'b0;
            if (last_jc) begin
              // compare labels: a_q target label
              if (a_q == rd_q) begin
                if (!hh_q || dist_q < bh_q) begin
                  hh_q <= 1'b1; bh_q <= dist_q; hr_q <= i_q;
                end
              end else begin
                if (!hm_q || dist_q < bm_q) begin
                  hm_q <= 1'b1; bm_q <= dist_q; mr_q <= i_q;
                end
              end
            end else begin
              dist_q <= dsum; jc_q <= jc_q + FW'(1);
            end
          end
        end
        StRowDone: begin
          i_q <= i_q + RW'(1); base_i_q <= base_i_q + stride;
          if (last_row) begin
            j_q <= '0; tp_q <= 1'b0; phase_q <= 1'b0;
          end
        end
        StTermInit: begin
          base_i_q <= AW'(hr_q) * stride;
        end
        StTermRd: ;
        StTermWait: begin
          if (!phase_q) begin
            a_q <= rd_q; phase_q <= 1'b1;
          end else begin
            range_q <= rng_c;
          end
        end
        StTermDiv: ;
        StTermAcc: begin
          phase_q <= 1'b0;
          if (range_q != '0 && (tp_q ? hm_q : hh_q)) begin
            if (tp_q) w_q[j_q] <= w_q[j_q] + WW'(q_sat);
            else      w_q[j_q] <= w_q[j_q] - WW'(q_sat);
          end
          if (!tp_q) begin
            tp_q <= 1'b1; base_i_q <= AW'(mr_q) * stride;
          end else begin
            tp_q <= 1'b0; base_i_q <= AW'(hr_q) * stride;
            j_q <= j_q + JW'(1);
            if (last_j) begin
              r_q <= r_q + RW'(1); base_r_q <= base_r_q + stride;
            end
          end
        end
        StSelInit: begin
          j_q <= '0; found_q <= 1'b0; best_q <= '0;
        end
        StSelScan: begin
          if (!sel_q[j_q] && (!found_q || w_q[j_q] > w_q[best_q])) begin
            found_q <= 1'b1; best_q <= j_q;
          end
          j_q <= j_q + JW'(1);
        end
        StSelMark: begin
          sel_q[best_q] <= 1'b1; k_q <= k_q + TW'(1);
          j_q <= '0; found_q <= 1'b0; best_q <= '0;
        end
        StEmit: if (!ovalid_q || out_ready_i) begin
          if (sel_q[j_q]) begin
            oidx_q <= 5'(j_q);
            olast_q <= !more_after;
          end else begin
            j_q <= j_q + JW'(1);
          end
        end
        StOut: begin
          j_q <= j_q + JW'(1);
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o     = ovalid_q;
  assign feature_index_o = oidx_q;
  assign last_o          = olast_q;
endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rfr_pkg::*;

  localparam int StoreDepth = MaxInstances * (MaxFeatures + 1);
  localparam int IdleLimit  = 2000000;

  typedef struct {
    logic signed [15:0] value;
    logic               eos;
  } beat_t;

  typedef struct {
    logic [4:0] index;
    logic       last;
  } pick_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready_o;
  logic signed [15:0]  value = '0;
  logic                end_of_set = 1'b0;
  logic                out_valid_o;
  logic                out_ready = 1'b0;
  logic [4:0]          feature_index_o;
  logic                last_o;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  relief_feature_ranker_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .value_i        (value),
    .end_of_set_i   (end_of_set),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .feature_index_o(feature_index_o),
    .last_o         (last_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  beat_t  pending_beats[$];
  pick_t  expected_picks[$];
  bit     no_idle = 0;
  int     errors = 0;
  int     in_gap = 0;
  int     out_gap = 0;
  int     idle_cycles = 0;

  longint         inst_store[StoreDepth];
  longint         fmax[MaxFeatures];
  longint         fmin[MaxFeatures];
  longint         weight[MaxFeatures];
  int unsigned    load_pos = 0;
  logic [8:0]     reg_instances = 9'd2;
  logic [5:0]     reg_features = 6'd1;
  logic [8:0]     reg_iterations = 9'd1;
  logic [5:0]     reg_top = 6'd1;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int eff_features(logic [5:0] raw);
    return (raw < 1) ? 1 : ((raw > MaxFeatures) ? MaxFeatures : int'(raw));
  endfunction

  function automatic int eff_instances(logic [8:0] raw);
    return (raw > MaxInstances) ? MaxInstances : int'(raw);
  endfunction

  function automatic longint cell_at(int r, int c, int nf);
    int idx;
    idx = r * (nf + 1) + c;
    return (idx < StoreDepth) ? inst_store[idx] : 0;
  endfunction

  function automatic longint diff_term(int tr, int sr, int j, int nf);
    longint range, d, q;
    range = fmax[j] - fmin[j];
    if (range == 0) return 0;
    d = cell_at(tr, j, nf) - cell_at(sr, j, nf);
    if (d < 0) d = -d;
    q = (d <<< 16) / range;
    return (q > 65535) ? 65535 : q;
  endfunction

  function automatic void rank_features();
    int n, nf, m, t, best, cnt;
    longint d, hit_d, miss_d, a;
    bit have_hit, have_miss, found;
    int hit_r, miss_r;
    logic [31:0] mask;
    pick_t p;
    n  = eff_instances(reg_instances);
    nf = eff_features(reg_features);
    m  = (reg_iterations > n) ? n : int'(reg_iterations);
    t  = (reg_top < 1) ? 1 : ((reg_top > nf) ? nf : int'(reg_top));
    for (int j = 0; j < nf; j++) begin
      fmax[j] = cell_at(0, j, nf);
      fmin[j] = cell_at(0, j, nf);
      for (int r = 1; r < n; r++) begin
        if (cell_at(r, j, nf) > fmax[j]) fmax[j] = cell_at(r, j, nf);
        if (cell_at(r, j, nf) < fmin[j]) fmin[j] = cell_at(r, j, nf);
      end
      weight[j] = 0;
    end
    for (int r = 0; r < m; r++) begin
      have_hit = 0;
      have_miss = 0;
      hit_d = 0;
      miss_d = 0;
      hit_r = 0;
      miss_r = 0;
      for (int i = 0; i < n; i++) begin
        if (i == r) continue;
        d = 0;
        for (int j = 0; j < nf; j++) begin
          a = cell_at(r, j, nf) - cell_at(i, j, nf);
          d += (a < 0) ? -a : a;
        end
        if (cell_at(i, nf, nf) == cell_at(r, nf, nf)) begin
          if (!have_hit || d < hit_d) begin
            have_hit = 1; hit_d = d; hit_r = i;
          end
        end else if (!have_miss || d < miss_d) begin
          have_miss = 1; miss_d = d; miss_r = i;
        end
      end
      for (int j = 0; j < nf; j++) begin
        if (have_hit) weight[j] -= diff_term(r, hit_r, j, nf);
        if (have_miss) weight[j] += diff_term(r, miss_r, j, nf);
      end
    end
    mask = '0;
    for (int k = 0; k < t; k++) begin
      found = 0;
      best = 0;
      for (int j = 0; j < nf; j++) begin
        if (mask[j]) continue;
        if (!found || weight[j] > weight[best]) begin
          found = 1; best = j;
        end
      end
      mask[best] = 1'b1;
    end
    cnt = 0;
    for (int j = 0; j < nf; j++) begin
      if (mask[j]) begin
        cnt++;
        p.index = j[4:0];
        p.last = (cnt == t);
        expected_picks.push_back(p);
      end
    end
  endfunction

  function automatic void load_beat(beat_t b);
    if (load_pos < StoreDepth) begin
      inst_store[load_pos] = longint'(b.value);
      load_pos++;
    end
    if (b.eos) begin
      load_pos = 0;
      rank_features();
    end
  endfunction

  // value beats
  always @(posedge clk_i) begin
    if (!(in_valid && !in_ready_o)) begin
      if (in_valid && in_ready_o) load_beat('{value, end_of_set});
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        beat_t b;
        b = pending_beats.pop_front();
        in_valid <= 1'b1;
        value <= b.value;
        end_of_set <= b.eos;
        in_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // index beats
  always @(posedge clk_i) begin
    int g;
    if (out_valid_o && out_ready) begin
      if (expected_picks.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected index beat %0d last %0b", feature_index_o, last_o);
      end else begin
        pick_t p;
        p = expected_picks.pop_front();
        if (p.index !== feature_index_o || p.last !== last_o) begin
          errors++;
          if (errors <= 10)
            $display("index mismatch: exp %0d/%0b got %0d/%0b",
                     p.index, p.last, feature_index_o, last_o);
        end
      end
      g = pick_gap();
      out_gap <= g;
      out_ready <= (g == 0);
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_ni;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || (cfg_valid && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      RegInstanceCount: reg_instances = data;
      RegFeatureCount:  reg_features = data[5:0];
      RegIterations:    reg_iterations = data;
      RegTopCount:      reg_top = data[5:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(int n, int nf, int m, int t);
    write_reg(RegInstanceCount, CfgDataW'(n));
    write_reg(RegFeatureCount, CfgDataW'(nf));
    write_reg(RegIterations, CfgDataW'(m));
    write_reg(RegTopCount, CfgDataW'(t));
  endtask

  task automatic wait_idle();
    while (pending_beats.size() != 0 || in_valid || expected_picks.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // mode 0 random full range, 1 small values, 2 constant, 3 extremes
  function automatic logic signed [15:0] feature_value(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 40) - 20);
      2: return 16'sd100;
      default: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  // label_mode 0 two classes, 1 all same, 2 all distinct, 3 random 16 bits
  task automatic queue_set(int mode, int label_mode, int extra);
    int n, nf, total;
    beat_t b;
    n = eff_instances(reg_instances);
    nf = eff_features(reg_features);
    if (n < 1) n = 1;
    total = n * (nf + 1) + extra;
    for (int k = 0; k < total; k++) begin
      if (k % (nf + 1) == nf) begin
        case (label_mode)
          0: b.value = 16'($urandom_range(0, 1) << 8);
          1: b.value = 16'sh0100;
          2: b.value = 16'(k);
          default: b.value = 16'($urandom);
        endcase
      end else begin
        b.value = feature_value(mode);
      end
      b.eos = (k == total - 1);
      pending_beats.push_back(b);
    end
  endtask

  task automatic queue_tie_set();
    beat_t b;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        b.value = (c == 2) ? ((r == 0 || r == 2) ? 16'sh0100 : 16'sh0) :
                  (r == 0 ? 16'sd0 : 16'sd5);
        b.eos = (r == 3 && c == 2);
        pending_beats.push_back(b);
      end
    end
  endtask

  initial begin
    int sent;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    queue_set(3, 2, 0);
    wait_idle();
    configure(3, 2, 3, 2);
    queue_set(1, 1, 0);
    wait_idle();
    queue_set(0, 2, 0);
    wait_idle();
    queue_set(2, 0, 0);
    wait_idle();
    configure(4, 2, 4, 1);
    queue_tie_set();
    wait_idle();
    configure(0, 0, 0, 0);
    queue_set(0, 0, 0);
    wait_idle();
    configure(1, 3, 511, 63);
    queue_set(3, 0, 0);
    wait_idle();
    configure(2, 63, 2, 32);
    queue_set(0, 3, 0);
    wait_idle();

    sent = 0;
    while (sent < 40) begin
      int n, nf;
      no_idle = ($urandom_range(0, 3) == 0);
      n = $urandom_range(2, 6);
      nf = $urandom_range(1, 5);
      configure(n, nf, $urandom_range(1, n + 2), $urandom_range(1, nf + 1));
      if ($urandom_range(0, 5) == 0) begin
        for (int k = 0; k < $urandom_range(1, 6); k++)
          pending_beats.push_back('{16'($urandom), 1'b0});
      end
      queue_set($urandom_range(0, 3), $urandom_range(0, 9) < 7 ? 0 : 3, 0);
      sent += n * (nf + 1);
      wait_idle();
    end
    no_idle = 0;

    repeat (50) @(posedge clk_i);
    if (errors == 0 && expected_picks.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
